>>> rtl/ftg_pkg.sv
// Shared types, constants and helpers of the foot trajectory generator.
// No dependencies; used by every other file of the block.
package ftg_pkg;

  // Fixed-point format of positions and velocities
  localparam int FracBits = 12;

  // Stream and configuration port widths
  localparam int InDataW  = 152;
  localparam int OutDataW = 112;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;

  // Queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  // Microseconds per second, for the short time checks
  localparam int Million = 1000000;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegFreq   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDuty   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLenLim = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidLim = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLift   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStOff  = 3'd5;

  typedef struct packed {
    logic        [15:0] freq;
    logic        [16:0] duty;
    logic        [14:0] len;
    logic        [14:0] wid;
    logic signed [15:0] lift;
    logic signed [15:0] stoff;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               swing;
    logic        [16:0] s;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  // Divide by 2^k, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned k);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q   = (mag + (64'd1 << (k - 1))) >> k;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

>>> rtl/ftg_front.sv
// Front end: input register, progress clamp and body-frame step velocity terms.
// Depends on ftg_pkg; feeds ftg_fifo.
module ftg_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // hip_x, hip_y, nominal_x, nominal_y, nominal_z, vel_x, vel_y, yaw_rate, progress
  input  logic [ftg_pkg::InDataW-1:0]   s_axis_tdata,
  // swinging
  input  logic                          s_axis_tuser,
  input  logic                          full_i,
  output logic                          push_o,
  output ftg_pkg::req_t                 req_o
);

  logic         fv_q, fv_d;
  logic [144:0] data_q;
  logic         swing_q;

  logic signed [15:0] hx, hy, vx, vy, wz;
  logic        [16:0] prog;
  logic signed [31:0] hy_wz, hx_wz;

  assign push_o        = fv_q && !full_i;
  assign s_axis_tready = !fv_q || !full_i;

  // Holding register valid
  always_comb begin
    fv_d = fv_q;
    if (s_axis_tvalid && s_axis_tready) begin
      fv_d = 1'b1;
    end else if (push_o) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data_q  <= s_axis_tdata[144:0];
      swing_q <= s_axis_tuser;
    end
  end

  // Field unpacking
  assign hx   = data_q[15:0];
  assign hy   = data_q[31:16];
  assign vx   = data_q[95:80];
  assign vy   = data_q[111:96];
  assign wz   = data_q[127:112];
  assign prog = data_q[144:128];

  // Yaw contribution at the hip
  assign hy_wz = hy * wz;
  assign hx_wz = hx * wz;

  always_comb begin
    req_o.ax    = (33'(vx) <<< ftg_pkg::FracBits) + 33'(hy_wz);
    req_o.ay    = (33'(vy) <<< ftg_pkg::FracBits) - 33'(hx_wz);
    req_o.nx    = data_q[47:32];
    req_o.ny    = data_q[63:48];
    req_o.nz    = data_q[79:64];
    req_o.swing = swing_q;
    // progress above one counts as one
    req_o.s     = (prog > 17'd65536) ? 17'd65536 : prog;
  end

endmodule

>>> rtl/ftg_fifo.sv
// Short request queue between the front end and the arithmetic back end.
// Depends on ftg_pkg for the entry and status types.
module ftg_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ftg_pkg::req_t      wdata_i,
  input  logic               pop_i,
  output ftg_pkg::req_t      rdata_o,
  output ftg_pkg::fifo_st_t  status_o
);

  ftg_pkg::req_t                   mem_q [ftg_pkg::FifoDepth];
  logic [ftg_pkg::FifoPtrW-1:0]    wr_q, rd_q;
  logic [ftg_pkg::FifoCntW-1:0]    cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == ftg_pkg::FifoCntW'(ftg_pkg::FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/ftg_back.sv
// Back end: pipelined half-step divider, Bezier/stance evaluation, pipelined
// velocity divider and the output register. Depends on ftg_pkg.
module ftg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ftg_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  input  ftg_pkg::req_t                 in_data_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, pos_z, speed_x, speed_y, speed_z, zero fill
  output logic [ftg_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int MW = 51;                          // |a * duty|
  localparam int NW = MW + 1 - (ftg_pkg::FracBits + 9);
  localparam int SQ = 15;                          // half step quotient bits
  localparam int VW = 44;                          // velocity numerator
  localparam int VQ = 20;                          // velocity quotient bits

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               swing;
    logic        [16:0] s;
  } pl_t;

  typedef struct packed {
    pl_t                 pl;
    logic [1:0]          sgn;
    logic [1:0]          ovf;
    logic [1:0][NW-1:0]  rem;
    logic [1:0][SQ-1:0]  q;
  } sd_t;

  typedef struct packed {
    logic signed [18:0]  px;
    logic signed [18:0]  py;
    logic signed [17:0]  pz;
    logic                zero;
    logic                shrt;
    logic [16:0]         dv;
    logic [2:0]          sgn;
    logic [2:0]          nzv;
    logic [2:0]          ovf;
    logic [2:0][VW-1:0]  rem;
    logic [2:0][VQ-1:0]  q;
  } vd_t;

  // Whole back end moves together when the output register can take data
  logic adv;
  assign adv   = !m_axis_tvalid || m_axis_tready;
  assign pop_o = adv && in_valid_i;

  // Static terms of the timing checks
  logic signed [17:0] swd;
  logic        [37:0] swd_us, duty_us, freq8;
  logic               swing_ok, stance_short, freq_nz;
  logic signed [17:0] lift3;

  assign swd          = 18'sd65536 - $signed({1'b0, cfg_i.duty});
  assign swd_us       = 38'(swd[16:0]) * 38'(ftg_pkg::Million);
  assign duty_us      = 38'(cfg_i.duty) * 38'(ftg_pkg::Million);
  assign freq8        = 38'({cfg_i.freq, 8'b0});
  assign freq_nz      = (cfg_i.freq != '0);
  assign swing_ok     = (swd > 18'sd0) && (swd_us > freq8);
  assign stance_short = (duty_us < freq8);
  assign lift3        = (18'(cfg_i.lift) <<< 1) + 18'(cfg_i.lift);

  // ---------------- stage b0: a * duty ----------------
  logic               b0_v_q;
  pl_t                b0_pl_q;
  logic signed [50:0] b0_mx_q, b0_my_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b0_pl_q <= '{nx: in_data_i.nx, ny: in_data_i.ny, nz: in_data_i.nz,
                   swing: in_data_i.swing, s: in_data_i.s};
      b0_mx_q <= 51'(in_data_i.ax) * $signed({34'b0, cfg_i.duty});
      b0_my_q <= 51'(in_data_i.ay) * $signed({34'b0, cfg_i.duty});
    end
  end

  // ---------------- stage b1: rounded numerator over 2^(F+9) ----------------
  logic              b1_v_q;
  pl_t               b1_pl_q;
  logic [1:0]        b1_sgn_q;
  logic [1:0][NW-1:0] b1_n_q;
  logic [MW-1:0]     magx, magy;
  logic [MW:0]       sumx, sumy, half;

  assign magx = b0_mx_q[MW-1] ? MW'(-b0_mx_q) : MW'(b0_mx_q);
  assign magy = b0_my_q[MW-1] ? MW'(-b0_my_q) : MW'(b0_my_q);
  assign half = (MW + 1)'(cfg_i.freq) << (ftg_pkg::FracBits + 8);
  assign sumx = {1'b0, magx} + half;
  assign sumy = {1'b0, magy} + half;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_pl_q   <= b0_pl_q;
      b1_sgn_q  <= {b0_my_q[MW-1], b0_mx_q[MW-1]};
      b1_n_q[0] <= sumx[MW:ftg_pkg::FracBits + 9];
      b1_n_q[1] <= sumy[MW:ftg_pkg::FracBits + 9];
    end
  end

  // ---------------- half step divider, one quotient bit per stage ----------------
  logic [SQ:0] sd_v_q;
  sd_t         sd_q [SQ + 1];
  sd_t         sd_d [SQ + 1];

  always_comb begin
    logic [NW-1:0] dk;
    int            k;
    // first stage flags quotients that cannot fit
    sd_d[0].pl  = b1_pl_q;
    sd_d[0].sgn = b1_sgn_q;
    sd_d[0].rem = b1_n_q;
    sd_d[0].q   = '0;
    for (int l = 0; l < 2; l++) begin
      sd_d[0].ovf[l] = (b1_n_q[l] >= (NW'(cfg_i.freq) << SQ));
    end
    for (int j = 1; j <= SQ; j++) begin
      k        = SQ - j;
      sd_d[j]  = sd_q[j-1];
      dk       = NW'(cfg_i.freq) << k;
      for (int l = 0; l < 2; l++) begin
        if (sd_q[j-1].rem[l] >= dk) begin
          sd_d[j].rem[l]  = sd_q[j-1].rem[l] - dk;
          sd_d[j].q[l][k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j <= SQ; j++) begin
        sd_q[j] <= sd_d[j];
      end
    end
  end

  // ---------------- c0: clamp step, phase products ----------------
  logic               c0_v_q;
  pl_t                c0_pl_q;
  logic signed [15:0] c0_stx_q, c0_sty_q;
  logic signed [16:0] c0_stx2_q, c0_sty2_q;
  logic signed [19:0] c0_stx12_q, c0_sty12_q;
  logic        [30:0] c0_us_q;
  logic        [32:0] c0_ss_q;
  logic        [18:0] c0_t3_q;
  logic signed [17:0] c0_ums_q;

  logic        [14:0] lim [2];
  logic        [14:0] mq;
  logic signed [15:0] st [2];
  logic        [16:0] u;
  logic        [33:0] us_full, ss_full;
  sd_t                sdo;

  assign sdo = sd_q[SQ];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mq     = sdo.ovf[l] ? '1 : sdo.q[l];
      lim[l] = (l == 0) ? ((mq > cfg_i.len) ? cfg_i.len : mq)
                        : ((mq > cfg_i.wid) ? cfg_i.wid : mq);
      if (!freq_nz) begin
        lim[l] = '0;
      end
      st[l]  = sdo.sgn[l] ? -$signed({1'b0, lim[l]}) : $signed({1'b0, lim[l]});
    end
  end

  assign u       = 17'd65536 - sdo.pl.s;
  assign us_full = {17'b0, u} * {17'b0, sdo.pl.s};
  assign ss_full = {17'b0, sdo.pl.s} * {17'b0, sdo.pl.s};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0_pl_q    <= sdo.pl;
      c0_stx_q   <= st[0];
      c0_sty_q   <= st[1];
      c0_stx2_q  <= 17'(st[0]) <<< 1;
      c0_sty2_q  <= 17'(st[1]) <<< 1;
      c0_stx12_q <= (20'(st[0]) <<< 3) + (20'(st[0]) <<< 2);
      c0_sty12_q <= (20'(st[1]) <<< 3) + (20'(st[1]) <<< 2);
      c0_us_q    <= us_full[30:0];
      c0_ss_q    <= ss_full[32:0];
      c0_t3_q    <= 19'(u) + 19'(u) + 19'(u) + 19'(sdo.pl.s);
      c0_ums_q   <= 18'sd65536 - $signed({1'b0, sdo.pl.s}) - $signed({1'b0, sdo.pl.s});
    end
  end

  // ---------------- c1: Bezier and sweep products ----------------
  logic               c1_v_q;
  pl_t                c1_pl_q;
  logic signed [15:0] c1_stx_q, c1_sty_q;
  logic signed [16:0] c1_stx2_q, c1_sty2_q;
  logic        [51:0] c1_hn_q;
  logic signed [50:0] c1_dxn_q, c1_dyn_q;
  logic signed [49:0] c1_pzn_q;
  logic signed [35:0] c1_psxn_q, c1_psyn_q, c1_dzn_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_pl_q   <= c0_pl_q;
      c1_stx_q  <= c0_stx_q;
      c1_sty_q  <= c0_sty_q;
      c1_stx2_q <= c0_stx2_q;
      c1_sty2_q <= c0_sty2_q;
      c1_hn_q   <= {19'b0, c0_ss_q} * {33'b0, c0_t3_q};
      c1_dxn_q  <= 51'(c0_stx12_q) * $signed({20'b0, c0_us_q});
      c1_dyn_q  <= 51'(c0_sty12_q) * $signed({20'b0, c0_us_q});
      c1_pzn_q  <= 50'(lift3) * $signed({19'b0, c0_us_q});
      c1_psxn_q <= 36'(c0_stx2_q) * $signed({19'b0, c0_pl_q.s});
      c1_psyn_q <= 36'(c0_sty2_q) * $signed({19'b0, c0_pl_q.s});
      c1_dzn_q  <= 36'(lift3) * 36'(c0_ums_q);
    end
  end

  // ---------------- c2: rounding ----------------
  logic               c2_v_q;
  pl_t                c2_pl_q;
  logic signed [15:0] c2_stx_q, c2_sty_q;
  logic signed [16:0] c2_stx2_q, c2_sty2_q;
  logic        [16:0] c2_h16_q;
  logic signed [17:0] c2_dx_q, c2_dy_q, c2_dz_q, c2_psx_q, c2_psy_q;
  logic signed [16:0] c2_pzo_q;
  logic signed [63:0] h64;

  assign h64 = ftg_pkg::rnd_shift($signed(64'(c1_hn_q)), 32);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_pl_q   <= c1_pl_q;
      c2_stx_q  <= c1_stx_q;
      c2_sty_q  <= c1_sty_q;
      c2_stx2_q <= c1_stx2_q;
      c2_sty2_q <= c1_sty2_q;
      c2_h16_q  <= h64[16:0];
      c2_dx_q   <= 18'(ftg_pkg::rnd_shift(64'(c1_dxn_q), 32));
      c2_dy_q   <= 18'(ftg_pkg::rnd_shift(64'(c1_dyn_q), 32));
      c2_pzo_q  <= 17'(ftg_pkg::rnd_shift(64'(c1_pzn_q), 32));
      c2_psx_q  <= 18'(ftg_pkg::rnd_shift(64'(c1_psxn_q), 16));
      c2_psy_q  <= 18'(ftg_pkg::rnd_shift(64'(c1_psyn_q), 16));
      c2_dz_q   <= 18'(ftg_pkg::rnd_shift(64'(c1_dzn_q), 16));
    end
  end

  // ---------------- c3: swing position product, velocity numerators ----------------
  logic               c3_v_q;
  pl_t                c3_pl_q;
  logic signed [15:0] c3_stx_q, c3_sty_q;
  logic signed [17:0] c3_psx_q, c3_psy_q;
  logic signed [16:0] c3_pzo_q;
  logic signed [35:0] c3_pxm_q, c3_pym_q;
  logic signed [35:0] c3_vn_q [3];
  logic signed [17:0] selx, sely, selz;
  logic signed [35:0] frq36;

  assign frq36 = $signed({20'b0, cfg_i.freq});
  assign selx  = c2_pl_q.swing ? c2_dx_q : -18'(c2_stx2_q);
  assign sely  = c2_pl_q.swing ? c2_dy_q : -18'(c2_sty2_q);
  assign selz  = c2_pl_q.swing ? c2_dz_q : 18'sd0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c3_pl_q    <= c2_pl_q;
      c3_stx_q   <= c2_stx_q;
      c3_sty_q   <= c2_sty_q;
      c3_psx_q   <= c2_psx_q;
      c3_psy_q   <= c2_psy_q;
      c3_pzo_q   <= c2_pzo_q;
      c3_pxm_q   <= 36'(c2_stx2_q) * $signed({19'b0, c2_h16_q});
      c3_pym_q   <= 36'(c2_sty2_q) * $signed({19'b0, c2_h16_q});
      c3_vn_q[0] <= 36'(selx) * frq36;
      c3_vn_q[1] <= 36'(sely) * frq36;
      c3_vn_q[2] <= 36'(selz) * frq36;
    end
  end

  // ---------------- c4 / velocity divider ----------------
  logic [VQ+1:0] vd_v_q;
  vd_t           vd_q [VQ + 2];
  vd_t           vd_d [VQ + 2];
  logic signed [17:0] pxr, pyr;
  logic        [35:0] vmag [3];
  logic        [16:0] dsel;

  assign pxr  = 18'(ftg_pkg::rnd_shift(64'(c3_pxm_q), 16));
  assign pyr  = 18'(ftg_pkg::rnd_shift(64'(c3_pym_q), 16));
  assign dsel = c3_pl_q.swing ? swd[16:0] : cfg_i.duty;

  always_comb begin
    logic [VW-1:0] dk;
    int            k;
    // positions and rounded velocity numerators
    if (c3_pl_q.swing) begin
      vd_d[0].px = 19'(c3_pl_q.nx) - 19'(c3_stx_q) + 19'(pxr);
      vd_d[0].py = 19'(c3_pl_q.ny) - 19'(c3_sty_q) + 19'(pyr);
      vd_d[0].pz = 18'(c3_pl_q.nz) + 18'(c3_pzo_q);
    end else begin
      vd_d[0].px = 19'(c3_pl_q.nx) + 19'(c3_stx_q) - 19'(c3_psx_q);
      vd_d[0].py = 19'(c3_pl_q.ny) + 19'(c3_sty_q) - 19'(c3_psy_q);
      vd_d[0].pz = 18'(c3_pl_q.nz) + 18'(cfg_i.stoff);
    end
    vd_d[0].zero = !freq_nz || (c3_pl_q.swing && !swing_ok);
    vd_d[0].shrt = !c3_pl_q.swing && stance_short;
    vd_d[0].dv   = dsel;
    vd_d[0].ovf  = '0;
    vd_d[0].q    = '0;
    for (int l = 0; l < 3; l++) begin
      vmag[l]           = c3_vn_q[l][35] ? 36'(-c3_vn_q[l]) : 36'(c3_vn_q[l]);
      vd_d[0].sgn[l]    = c3_vn_q[l][35];
      vd_d[0].nzv[l]    = (c3_vn_q[l] != '0);
      vd_d[0].rem[l]    = (VW'(vmag[l]) << 8) + VW'(dsel >> 1);
    end
    // overflow check
    vd_d[1] = vd_q[0];
    for (int l = 0; l < 3; l++) begin
      vd_d[1].ovf[l] = (vd_q[0].rem[l] >= (VW'(vd_q[0].dv) << VQ));
    end
    // one quotient bit per stage
    for (int j = 2; j <= VQ + 1; j++) begin
      k       = VQ + 1 - j;
      vd_d[j] = vd_q[j-1];
      dk      = VW'(vd_q[j-1].dv) << k;
      for (int l = 0; l < 3; l++) begin
        if (vd_q[j-1].rem[l] >= dk) begin
          vd_d[j].rem[l]  = vd_q[j-1].rem[l] - dk;
          vd_d[j].q[l][k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j <= VQ + 1; j++) begin
        vd_q[j] <= vd_d[j];
      end
    end
  end

  // ---------------- output register ----------------
  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'h7fff;
    end else if (v < -19'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [VQ-1:0] vel_out(input logic zero, input logic shrt,
                                            input logic sgn, input logic nzv,
                                            input logic ovf, input logic [VQ-1:0] q);
    logic [VQ-1:0] vmax, vmin;
    vmax = {1'b0, {(VQ-1){1'b1}}};
    vmin = {1'b1, {(VQ-1){1'b0}}};
    if (zero) begin
      return '0;
    end else if (shrt) begin
      return nzv ? (sgn ? vmin : vmax) : '0;
    end else if (sgn) begin
      return (ovf || (q > vmin)) ? vmin : VQ'(-q);
    end
    return (ovf || q[VQ-1]) ? vmax : q;
  endfunction

  vd_t vdo;
  assign vdo = vd_q[VQ+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= {4'b0,
        vel_out(vdo.zero, vdo.shrt, vdo.sgn[2], vdo.nzv[2], vdo.ovf[2], vdo.q[2]),
        vel_out(vdo.zero, vdo.shrt, vdo.sgn[1], vdo.nzv[1], vdo.ovf[1], vdo.q[1]),
        vel_out(vdo.zero, vdo.shrt, vdo.sgn[0], vdo.nzv[0], vdo.ovf[0], vdo.q[0]),
        sat16(19'(vdo.pz)), sat16(vdo.py), sat16(vdo.px)};
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q        <= 1'b0;
      b1_v_q        <= 1'b0;
      sd_v_q        <= '0;
      c0_v_q        <= 1'b0;
      c1_v_q        <= 1'b0;
      c2_v_q        <= 1'b0;
      c3_v_q        <= 1'b0;
      vd_v_q        <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      b0_v_q        <= in_valid_i;
      b1_v_q        <= b0_v_q;
      sd_v_q        <= {sd_v_q[SQ-1:0], b1_v_q};
      c0_v_q        <= sd_v_q[SQ];
      c1_v_q        <= c0_v_q;
      c2_v_q        <= c1_v_q;
      c3_v_q        <= c2_v_q;
      vd_v_q        <= {vd_v_q[VQ:0], c3_v_q};
      m_axis_tvalid <= vd_v_q[VQ+1];
    end
  end

endmodule

>>> rtl/foot_trajectory_generator.sv
// Top level of the foot trajectory generator: configuration registers,
// front end, request queue and arithmetic back end. Depends on ftg_pkg.

// One leg request per cycle is accepted and one result per cycle delivered
// when the output is not stalled. A request passes the input register and
// the queue, then a back-end pipeline whose length is set by two restoring
// dividers with an overflow check and then one quotient bit per stage (16
// stages for the half step, 22 for the velocities). Up to four requests queue
// between front and back, so the input keeps taking items while results
// wait. Configuration must be written while no request is in flight.
module foot_trajectory_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // hip_x, hip_y, nominal_x, nominal_y, nominal_z, vel_x, vel_y, yaw_rate, progress
  input  logic [ftg_pkg::InDataW-1:0]     s_axis_tdata,
  // swinging
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pos_x, pos_y, pos_z, speed_x, speed_y, speed_z
  output logic [ftg_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [ftg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ftg_pkg::CfgDataW-1:0]    cfg_data_i
);

  ftg_pkg::cfg_t     cfg_q;
  ftg_pkg::req_t     push_req, pop_req;
  ftg_pkg::fifo_st_t fst;
  logic              push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.freq  <= 16'd512;
      cfg_q.duty  <= 17'd39322;
      cfg_q.len   <= 15'd410;
      cfg_q.wid   <= 15'd205;
      cfg_q.lift  <= 16'sd328;
      cfg_q.stoff <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftg_pkg::RegFreq:   cfg_q.freq  <= cfg_data_i[15:0];
        ftg_pkg::RegDuty:   cfg_q.duty  <= cfg_data_i;
        ftg_pkg::RegLenLim: cfg_q.len   <= cfg_data_i[14:0];
        ftg_pkg::RegWidLim: cfg_q.wid   <= cfg_data_i[14:0];
        ftg_pkg::RegLift:   cfg_q.lift  <= cfg_data_i[15:0];
        ftg_pkg::RegStOff:  cfg_q.stoff <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ftg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (fst.full),
    .push_o        (push),
    .req_o         (push_req)
  );

  ftg_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_req),
    .pop_i    (pop),
    .rdata_o  (pop_req),
    .status_o (fst)
  );

  ftg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (!fst.empty),
    .in_data_i     (pop_req),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Queue never written while full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fst.full))
    else $error("request queue written while full");

  // Queue never read while empty
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && fst.empty))
    else $error("request queue read while empty");

  // Queue only fills up after a push
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fst.full) |-> $past(push))
    else $error("request queue became full without a push");

endmodule

>>> test/tb.sv
// Self-checking bench for foot_trajectory_generator: directed legs, then random
// legs under several register settings, each result checked against a predictor
// or a given expectation. Depends on ftg_pkg and the block's RTL.
module tb;
  import ftg_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd6;
  localparam logic [CfgIdxW-1:0] RegTop   = 3'd7;
  localparam int LimitCycles = 400000;

  typedef struct packed {
    logic signed [15:0] hip_x;
    logic signed [15:0] hip_y;
    logic signed [15:0] nom_x;
    logic signed [15:0] nom_y;
    logic signed [15:0] nom_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw;
    logic               swinging;
    logic        [16:0] progress;
  } leg_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [19:0] sx;
    logic signed [19:0] sy;
    logic signed [19:0] sz;
  } foot_t;

  typedef struct packed {
    leg_t  leg;
    logic  typed;
    foot_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = RegFreq;
  logic [CfgDataW-1:0] cfg_data = '0;

  // register copy kept by the bench
  longint g_freq, g_duty, g_len, g_wid, g_lift, g_stoff;
  foot_t foot_q[$];
  int errs = 0;
  int cycles = 0;
  bit jitter = 1'b1;

  foot_trajectory_generator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // rounded division, ties away from zero
  function automatic longint div_near(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    return clip(v, -hi - 1, hi);
  endfunction

  // foot position and velocity for one leg request
  function automatic foot_t foot_path(leg_t l);
    longint hx, hy, nx, ny, nz, vx, vy, wz, s, u, den, ax, ay;
    longint stx, sty, h16, swd, dx, dy, dz, px, py, pz, sx, sy, sz;
    foot_t f;
    hx = l.hip_x; hy = l.hip_y; nx = l.nom_x; ny = l.nom_y; nz = l.nom_z;
    vx = l.vel_x; vy = l.vel_y; wz = l.yaw;
    s = clip(longint'(l.progress), 0, 65536);
    stx = 0; sty = 0; sx = 0; sy = 0; sz = 0;
    if (g_freq != 0) begin
      den = g_freq * (longint'(1) << (FracBits + 9));
      ax = vx * 4096 + hy * wz;
      ay = vy * 4096 - hx * wz;
      stx = div_near(ax * g_duty, den);
      sty = div_near(ay * g_duty, den);
    end
    stx = clip(stx, -g_len, g_len);
    sty = clip(sty, -g_wid, g_wid);
    if (l.swinging) begin
      u = 65536 - s;
      h16 = div_near(s * s * (3 * u + s), longint'(1) << 32);
      swd = 65536 - g_duty;
      px = nx - stx + div_near(2 * stx * h16, 65536);
      py = ny - sty + div_near(2 * sty * h16, 65536);
      pz = nz + div_near(3 * g_lift * u * s, longint'(1) << 32);
      if (g_freq != 0 && swd > 0 && swd * Million > g_freq * 256) begin
        dx = div_near(12 * stx * u * s, longint'(1) << 32);
        dy = div_near(12 * sty * u * s, longint'(1) << 32);
        dz = div_near(3 * g_lift * (u - s), 65536);
        sx = div_near(dx * g_freq * 256, swd);
        sy = div_near(dy * g_freq * 256, swd);
        sz = div_near(dz * g_freq * 256, swd);
      end
    end else begin
      px = nx + stx - div_near(2 * stx * s, 65536);
      py = ny + sty - div_near(2 * sty * s, 65536);
      pz = nz + g_stoff;
      if (g_freq != 0) begin
        // very short stance time: divisor floors at one microsecond
        if (g_duty * Million < g_freq * 256) begin
          sx = -2 * stx * Million;
          sy = -2 * sty * Million;
        end else begin
          sx = div_near(-2 * stx * g_freq * 256, g_duty);
          sy = div_near(-2 * sty * g_freq * 256, g_duty);
        end
      end
    end
    f.px = 16'(sat(px, 16)); f.py = 16'(sat(py, 16)); f.pz = 16'(sat(pz, 16));
    f.sx = 20'(sat(sx, 20)); f.sy = 20'(sat(sy, 20)); f.sz = 20'(sat(sz, 20));
    return f;
  endfunction

  // register write, only while idle
  task automatic reg_write(logic [CfgIdxW-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegFreq:   g_freq = val & 64'hFFFF;
      RegDuty:   g_duty = val & 64'h1FFFF;
      RegLenLim: g_len = val & 64'h7FFF;
      RegWidLim: g_wid = val & 64'h7FFF;
      RegLift:   g_lift = longint'($signed(16'(val)));
      RegStOff:  g_stoff = longint'($signed(16'(val)));
      default: ;
    endcase
  endtask

  task automatic set_all(longint f, longint d, longint ln, longint wd, longint lf,
                         longint so);
    reg_write(RegFreq, f);
    reg_write(RegDuty, d);
    reg_write(RegLenLim, ln);
    reg_write(RegWidLim, wd);
    reg_write(RegLift, lf);
    reg_write(RegStOff, so);
  endtask

  // send one leg; expectation queued when the item is taken
  task automatic send_leg(leg_t l, logic typed, foot_t want);
    while (jitter && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= l.swinging;
    s_tdata <= InDataW'({l.progress, l.yaw, l.vel_y, l.vel_x, l.nom_z, l.nom_y,
                         l.nom_x, l.hip_y, l.hip_x});
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    foot_q.push_back(typed ? want : foot_path(l));
  endtask

  function automatic logic signed [15:0] rnd16();
    return ($urandom_range(1) == 1) ? 16'($urandom) : 16'($signed($urandom_range(8192)) - 4096);
  endfunction

  task automatic random_legs(int n);
    leg_t l;
    foot_t none;
    none = '0;
    repeat (n) begin
      l.hip_x = rnd16(); l.hip_y = rnd16(); l.nom_x = rnd16(); l.nom_y = rnd16();
      l.nom_z = rnd16(); l.vel_x = rnd16(); l.vel_y = rnd16(); l.yaw = rnd16();
      l.swinging = 1'($urandom);
      case ($urandom_range(9))
        0: l.progress = 17'($urandom_range(131071, 65537));
        1: l.progress = ($urandom_range(1) == 1) ? 17'd0 : 17'd65536;
        default: l.progress = 17'($urandom_range(65536));
      endcase
      send_leg(l, 1'b0, none);
    end
  endtask

  // let the pipeline empty before the registers change
  task automatic drain();
    s_tvalid <= 1'b0;
    while (foot_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // output side stalls at random while jitter is set
  always @(posedge clk_i) begin
    m_tready <= jitter ? ($urandom_range(99) >= 17) : 1'b1;
  end

  // result check
  always @(posedge clk_i) begin
    foot_t got, exp_f;
    if (rst_ni && m_tvalid && m_tready) begin
      got = foot_t'(m_tdata[107:0]);
      got = '{px: m_tdata[15:0], py: m_tdata[31:16], pz: m_tdata[47:32],
              sx: m_tdata[67:48], sy: m_tdata[87:68], sz: m_tdata[107:88]};
      if (foot_q.size() == 0) begin
        $display("%0t error: unexpected result, expected none actual %h", $time, got);
        errs++;
      end else begin
        exp_f = foot_q.pop_front();
        if (got.px !== exp_f.px) begin
          $display("%0t pos_x: expected %0d actual %0d", $time, exp_f.px, got.px); errs++;
        end
        if (got.py !== exp_f.py) begin
          $display("%0t pos_y: expected %0d actual %0d", $time, exp_f.py, got.py); errs++;
        end
        if (got.pz !== exp_f.pz) begin
          $display("%0t pos_z: expected %0d actual %0d", $time, exp_f.pz, got.pz); errs++;
        end
        if (got.sx !== exp_f.sx) begin
          $display("%0t speed_x: expected %0d actual %0d", $time, exp_f.sx, got.sx); errs++;
        end
        if (got.sy !== exp_f.sy) begin
          $display("%0t speed_y: expected %0d actual %0d", $time, exp_f.sy, got.sy); errs++;
        end
        if (got.sz !== exp_f.sz) begin
          $display("%0t speed_z: expected %0d actual %0d", $time, exp_f.sz, got.sz); errs++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // directed legs: hip, nominal, vel, yaw, swing, progress
  row_t dir_rows[14];

  initial begin
    foot_t zf;
    zf = '0;
    dir_rows[0]  = '{'{0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 17'd0}, 1'b1, zf};
    dir_rows[1]  = '{'{0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 17'd0}, 1'b1,
                     '{0, 0, 0, 0, 0, 20'sd4920}};
    dir_rows[2]  = '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                       16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 17'd65536}, 1'b0, zf};
    dir_rows[3]  = '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                       16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 17'd0}, 1'b0, zf};
    dir_rows[4]  = '{'{100, -100, 200, 300, -1000, 2048, -1024, 512, 1'b1, 17'h1ffff},
                     1'b0, zf};
    dir_rows[5]  = '{'{100, -100, 200, 300, -1000, 2048, -1024, 512, 1'b0, 17'h1ffff},
                     1'b0, zf};
    dir_rows[6]  = '{'{0, 0, 0, 0, -1200, 4096, 0, 0, 1'b1, 17'd32768}, 1'b0, zf};
    dir_rows[7]  = '{'{0, 0, 0, 0, -1200, -4096, 2048, 0, 1'b0, 17'd32768}, 1'b0, zf};
    dir_rows[8]  = '{'{16'sh7fff, 16'sh8000, 0, 0, 0, 0, 0, 16'sh7fff, 1'b1, 17'd16384},
                     1'b0, zf};
    dir_rows[9]  = '{'{16'sh8000, 16'sh7fff, 0, 0, 0, 0, 0, 16'sh8000, 1'b0, 17'd49152},
                     1'b0, zf};
    dir_rows[10] = '{'{0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 300, 300, 0, 1'b1,
                       17'd32768}, 1'b0, zf};
    dir_rows[11] = '{'{0, 0, 16'sh8000, 16'sh7fff, 16'sh8000, -300, -300, 0, 1'b1,
                       17'd1}, 1'b0, zf};
    dir_rows[12] = '{'{800, 600, 1000, -500, -1500, 1000, 500, -2000, 1'b0, 17'd65535},
                     1'b0, zf};
    dir_rows[13] = '{'{-800, -600, 1000, 500, -1500, -1000, -500, 2000, 1'b1, 17'd65535},
                     1'b0, zf};
  end

  initial begin
    g_freq = 512; g_duty = 39322; g_len = 410; g_wid = 205; g_lift = 328; g_stoff = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: directed rows then random
    foreach (dir_rows[i]) send_leg(dir_rows[i].leg, dir_rows[i].typed, dir_rows[i].want);
    random_legs(200);
    drain();

    // timing disabled
    set_all(0, 30000, 2000, 2000, 1000, -500);
    random_legs(200);
    drain();

    // very short stance, widest limits, top lift and offset
    set_all(65535, 1, 32767, 32767, 32767, 32767);
    random_legs(200);
    drain();

    // full duty: no swing time; smallest limits, bottom lift and offset
    set_all(1, 65536, 1, 1, -32768, -32768);
    random_legs(200);
    drain();

    // zero duty
    set_all(256, 0, 4000, 3000, 600, 100);
    random_legs(200);
    drain();

    // typical trot, no idling on either side; spare indexes must be ignored
    jitter = 1'b0;
    set_all(640, 40000, 500, 300, 400, -200);
    reg_write(RegSpare, 17'h1ffff);
    reg_write(RegTop, 17'h0);
    random_legs(220);
    drain();
    jitter = 1'b1;

    // random settings
    set_all($urandom_range(65535), $urandom_range(65536), $urandom_range(32767, 1),
            $urandom_range(32767, 1), $urandom_range(65535), $urandom_range(65535));
    random_legs(200);
    drain();

    // back to the power-up values
    set_all(512, 39322, 410, 205, 328, 0);
    random_legs(220);
    drain();

    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
